// ===== sv/clustered_hash_table_age_replace_macros.svh =====
// assertion macros shared by the table rtl
// no dependencies
`ifndef CLUSTERED_HASH_TABLE_AGE_REPLACE_MACROS_SVH
`define CLUSTERED_HASH_TABLE_AGE_REPLACE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define CHT_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CHT_ASSERT(lbl, clk, rst, prop)
`define CHT_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== sv/cht_pkg.sv =====
// types and constants for the clustered hash table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;
   localparam int CLUSTER_COUNT_DEF = 4096;
   localparam int WAYS_DEF = 3;
   localparam int GEN_PERIOD_DEF = 64;
   localparam int GEN_W = 8;
   localparam int SHALLOW_MARGIN = 4;

   localparam logic [1:0] ACT_READ = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_NEXT_GEN = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;
   localparam logic [1:0] BOUNDS_NONE = 2'd0;
   localparam logic [1:0] BOUNDS_EXACT = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [63:0] position_hash;
      logic signed [15:0] new_score;
      logic signed [15:0] new_static_eval;
      logic [15:0] new_depth;
      logic [1:0] new_bounds;
      logic [15:0] new_move;
   } req_type;

   typedef struct packed {
      logic hit;
      logic signed [15:0] found_score;
      logic signed [15:0] found_static_eval;
      logic [7:0] found_depth;
      logic [1:0] found_bounds;
      logic [15:0] found_move;
      logic [5:0] found_generation;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [15:0] score;
      logic [15:0] static_eval;
      logic [15:0] move;
      logic [7:0] depth;
      logic [1:0] bounds;
      logic [GEN_W-1:0] generation;
   } way_type;
endpackage
`default_nettype wire

// ===== sv/cht_front.sv =====
// front end: accepts requests, computes cluster index, queues commands
// depends on cht_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "clustered_hash_table_age_replace_macros.svh"
module cht_front #(
   parameter int CLUSTER_COUNT = cht_pkg::CLUSTER_COUNT_DEF,
   localparam int IDX_W = $clog2(CLUSTER_COUNT)
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire cht_pkg::req_type req_data,
   output logic cmd_valid,
   input wire logic cmd_take,
   output cht_pkg::req_type cmd_req,
   output logic [IDX_W-1:0] cmd_index
);
   // two-entry queue between front and back
   cht_pkg::req_type q_req_ff [2];
   logic [IDX_W-1:0] q_idx_ff [2];
   logic [1:0] count_ff, count_in;
   logic wr_ptr_ff, rd_ptr_ff;
   logic push_ok, take_ok;
   logic [63:0] prod_hi;
   logic [IDX_W-1:0] idx;

   // high word of hash * count; count is below 2^21 so a 64x21 product
   // is cut as two 32-bit halves
   logic [52:0] p_lo, p_hi;
   logic [64:0] p_sum;
   assign p_lo = {21'd0, req_data.position_hash[31:0]} * 53'(CLUSTER_COUNT);
   assign p_hi = {21'd0, req_data.position_hash[63:32]} * 53'(CLUSTER_COUNT);
   assign p_sum = {12'd0, p_hi} + {44'd0, p_lo[52:32]};
   assign prod_hi = {31'd0, p_sum[64:32]};
   assign idx = (prod_hi >= 64'(CLUSTER_COUNT)) ? IDX_W'(CLUSTER_COUNT - 1)
                                                : prod_hi[IDX_W-1:0];

   assign req_full = (count_ff == 2'd2);
   assign push_ok = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign take_ok = cmd_take && cmd_valid;
   assign cmd_req = q_req_ff[rd_ptr_ff];
   assign cmd_index = q_idx_ff[rd_ptr_ff];
   assign count_in = count_ff + {1'b0, push_ok} - {1'b0, take_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push_ok) wr_ptr_ff <= !wr_ptr_ff;
         if (take_ok) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_req_ff[wr_ptr_ff] <= req_data;
         q_idx_ff[wr_ptr_ff] <= idx;
      end
   end

   `CHT_ASSERT(a_cnt_max, clock, reset, count_ff != 2'd3)
   `CHT_ASSERT(a_ptr_sync, clock, reset, (count_ff != 2'd1) || (wr_ptr_ff != rd_ptr_ff))
   `CHT_ASSERT(a_empty_ptr, clock, reset, (count_ff != 2'd0) || (wr_ptr_ff == rd_ptr_ff))
endmodule
`default_nettype wire

// ===== sv/cht_back.sv =====
// back end: cluster memory, read/write probe, generation, clear sweep
// depends on cht_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "clustered_hash_table_age_replace_macros.svh"
module cht_back #(
   parameter int CLUSTER_COUNT = cht_pkg::CLUSTER_COUNT_DEF,
   parameter int WAYS = cht_pkg::WAYS_DEF,
   parameter int GEN_PERIOD = cht_pkg::GEN_PERIOD_DEF,
   localparam int IDX_W = $clog2(CLUSTER_COUNT),
   localparam int WAY_W = $bits(cht_pkg::way_type),
   localparam int WSEL_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_valid,
   output logic cmd_take,
   input wire cht_pkg::req_type cmd_req,
   input wire logic [IDX_W-1:0] cmd_index,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output cht_pkg::rsp_type rsp_data
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_PROBE = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   logic [WAYS*WAY_W-1:0] mem [CLUSTER_COUNT];
   logic [WAYS*WAY_W-1:0] row_ff;
   logic [2:0] state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff;
   logic [cht_pkg::GEN_W-1:0] gen_ff;
   cht_pkg::req_type req_ff;
   logic [IDX_W-1:0] idx_ff;
   cht_pkg::rsp_type out_ff, rsp_calc;
   logic out_valid_ff;
   // the done state after reset sweep carries no beat
   logic boot_ff;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [WAYS*WAY_W-1:0] mem_wdata, row_new;
   logic row_write;

   // a waiting beat holds off the next command unless it leaves this cycle
   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

   // probe logic on the registered row
   cht_pkg::way_type w [WAYS];
   cht_pkg::way_type sel, upd;
   logic [15:0] tag;
   logic [7:0] sat_depth;
   logic [WSEL_W-1:0] pick;
   logic found;
   logic signed [9:0] best, rel;
   logic [cht_pkg::GEN_W-1:0] age;
   logic same, shallow;

   always_comb begin
      for (int i = 0; i < WAYS; i++) w[i] = row_ff[i*WAY_W +: WAY_W];
      tag = req_ff.position_hash[15:0];
      sat_depth = (req_ff.new_depth > 16'd255) ? 8'd255 : req_ff.new_depth[7:0];
      rsp_calc = '0;
      found = 1'b0;
      age = '0;
      rel = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!found && w[i].tag == tag && w[i].bounds != cht_pkg::BOUNDS_NONE) begin
            found = 1'b1;
            rsp_calc.hit = 1'b1;
            rsp_calc.found_score = w[i].score;
            rsp_calc.found_static_eval = w[i].static_eval;
            rsp_calc.found_depth = w[i].depth;
            rsp_calc.found_bounds = w[i].bounds;
            rsp_calc.found_move = w[i].move;
            rsp_calc.found_generation = w[i].generation[5:0];
         end
      end
      if (req_ff.action != cht_pkg::ACT_READ) rsp_calc = '0;
      // replacement choice
      pick = '0;
      best = 10'sd511;
      found = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if (!found) begin
            if (w[i].tag == tag || w[i].bounds == cht_pkg::BOUNDS_NONE) begin
               found = 1'b1;
               pick = WSEL_W'(i);
            end else begin
               age = (gen_ff >= w[i].generation) ? gen_ff - w[i].generation
                   : cht_pkg::GEN_W'(GEN_PERIOD) + gen_ff - w[i].generation;
               rel = $signed({2'b00, w[i].depth}) - $signed({2'b00, age});
               if (rel < best) begin
                  best = rel;
                  pick = WSEL_W'(i);
               end
            end
         end
      end
      sel = w[pick];
      same = (sel.tag == tag);
      shallow = req_ff.new_bounds != cht_pkg::BOUNDS_EXACT && same
         && ({2'b00, sat_depth} + 10'(cht_pkg::SHALLOW_MARGIN) < {2'b00, sel.depth})
         && sel.generation == gen_ff;
      upd = sel;
      if (shallow) begin
         if (sel.move == 16'd0 && req_ff.new_move != 16'd0) upd.move = req_ff.new_move;
      end else begin
         if (req_ff.new_move != 16'd0 || !same) upd.move = req_ff.new_move;
         upd.score = req_ff.new_score;
         upd.static_eval = req_ff.new_static_eval;
         upd.depth = sat_depth;
         upd.bounds = req_ff.new_bounds;
         upd.generation = gen_ff;
         upd.tag = tag;
      end
      row_new = row_ff;
      row_new[pick*WAY_W +: WAY_W] = upd;
   end

   assign row_write = (state_ff == ST_PROBE) && req_ff.action == cht_pkg::ACT_WRITE;
   assign mem_we = (state_ff == ST_CLEAR) || row_write;
   assign mem_waddr = (state_ff == ST_CLEAR) ? sweep_ff : idx_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : row_new;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd_take) row_ff <= mem[cmd_index];
      if (cmd_take) begin
         req_ff <= cmd_req;
         idx_ff <= cmd_index;
      end
      if (state_ff == ST_PROBE) out_ff <= rsp_calc;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sweep_ff == IDX_W'(CLUSTER_COUNT - 1)) state_in = ST_DONE;
         ST_IDLE: if (cmd_take) state_in = ST_PROBE;
         ST_PROBE: state_in = (req_ff.action == cht_pkg::ACT_CLEAR) ? ST_CLEAR : ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // clear sweeps one row a cycle; the result beat of a clear waits for it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
         gen_ff <= '0;
         out_valid_ff <= 1'b0;
         boot_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) sweep_ff <= sweep_ff + 1'b1;
         if (state_ff == ST_PROBE) begin
            sweep_ff <= '0;
            boot_ff <= 1'b0;
            if (req_ff.action == cht_pkg::ACT_NEXT_GEN)
               gen_ff <= (gen_ff == cht_pkg::GEN_W'(GEN_PERIOD - 1)) ? '0 : gen_ff + 1'b1;
            if (req_ff.action == cht_pkg::ACT_CLEAR) gen_ff <= '0;
         end
         if (state_ff == ST_DONE && !boot_ff)
            out_valid_ff <= 1'b1;
         else if (rsp_pop && out_valid_ff)
            out_valid_ff <= 1'b0;
      end
   end

   `CHT_ASSERT(a_gen_range, clock, reset, gen_ff < cht_pkg::GEN_W'(GEN_PERIOD))
   `CHT_ASSERT(a_no_take_busy, clock, reset, !(cmd_take && out_valid_ff && !rsp_pop))
   `CHT_ASSERT(a_valid_idle, clock, reset, !out_valid_ff || state_ff == ST_IDLE)
   `CHT_ASSERT(a_probe_after_take, clock, reset, cmd_take |=> state_ff == ST_PROBE)
   `CHT_ASSERT(a_rsp_zero_nonread, clock, reset,
      (state_ff == ST_PROBE && req_ff.action != cht_pkg::ACT_READ) |=> !out_ff.hit)
endmodule
`default_nettype wire

// ===== sv/clustered_hash_table_age_replace.sv =====
// clustered hash table: a pushed request is queued, then taken with its cluster row read,
// probed with a read-modify-write, and its result is set valid from the done state;
// one item at a time; a waiting result holds off the next.
// clear adds a sweep over every cluster row before its result.
// after reset a clearing sweep over every cluster row runs before items are taken.
// reset is synchronous, active high.
`timescale 1ns / 1ps
`default_nettype none
module clustered_hash_table_age_replace #(
   parameter int CLUSTER_COUNT = cht_pkg::CLUSTER_COUNT_DEF,
   parameter int WAYS_PER_CLUSTER = cht_pkg::WAYS_DEF,
   parameter int GENERATION_PERIOD = cht_pkg::GEN_PERIOD_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire cht_pkg::req_type req_data,
   output logic empty,
   input wire logic pop,
   output cht_pkg::rsp_type rsp_data
);
   localparam int IDX_W = $clog2(CLUSTER_COUNT);
   logic cmd_valid, cmd_take;
   cht_pkg::req_type cmd_req;
   logic [IDX_W-1:0] cmd_index;

   cht_front #(.CLUSTER_COUNT(CLUSTER_COUNT)) u_front (
      .clock, .reset, .req_push(push), .req_full(full), .req_data,
      .cmd_valid, .cmd_take, .cmd_req, .cmd_index);

   cht_back #(.CLUSTER_COUNT(CLUSTER_COUNT), .WAYS(WAYS_PER_CLUSTER),
      .GEN_PERIOD(GENERATION_PERIOD)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_req, .cmd_index,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data);
endmodule
`default_nettype wire
